/* src/i2crm_pkg.sv */
// ----------------------------------------------------------------------------
// i2crm_pkg
// Types and constants shared by the I2C register master blocks.
// ----------------------------------------------------------------------------
package i2crm_pkg;

   localparam int MAX_BURST = 16;
   localparam int BURST_W   = 5;
   localparam int TIMER_W   = 16;

   // request codes
   localparam logic [1:0] REQ_NONE  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // configuration register indexes
   localparam logic CSR_DEVICE_ADDRESS = 1'b0;
   localparam logic CSR_HALF_PERIOD    = 1'b1;

   localparam logic [6:0]         DEVICE_ADDRESS_RESET = 7'd41;
   localparam logic [TIMER_W-1:0] HALF_PERIOD_RESET    = 16'd1500;

   typedef enum logic [3:0] {
      SEG_IDLE   = 4'd0,
      SEG_START  = 4'd1,
      SEG_ADDRW  = 4'd2,
      SEG_REG    = 4'd3,
      SEG_DATA   = 4'd4,
      SEG_RSTART = 4'd5,
      SEG_ADDRR  = 4'd6,
      SEG_READ   = 4'd7,
      SEG_STOP   = 4'd8
   } seg_type;

   typedef struct packed {
      logic [6:0]         device_address;
      logic [TIMER_W-1:0] half_period_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [7:0]         reg_addr;
      logic [7:0]         wr_data;
      logic [BURST_W-1:0] rd_count;
      logic               sda_in;
   } item_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_release;
      logic [7:0] rd_byte;
      logic       rd_valid;
      logic       rd_last;
      logic       nack_seen;
      logic       busy_res;
   } result_type;

endpackage

/* src/i2c_register_master_top.sv */
// ----------------------------------------------------------------------------
// i2c_register_master_top
// Tick-driven I2C master for register write and burst read transactions.
// ----------------------------------------------------------------------------
// a request is held in the input register, and its tick's result is captured
// in the result register before it is presented on rsp_valid
// throughput: one tick per unstalled cycle via the single-pass sequencer step
// the input register and the result register each keep their own valid bit
// reset (synchronous): bus idle with both lines released, nack flag clear,
// device address 41 and 1500 ticks per pin phase
module i2c_register_master_top
   import i2crm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [7:0]         req_reg_addr,
   input  logic [7:0]         req_wr_data,
   input  logic [BURST_W-1:0] req_rd_count,
   input  logic               req_sda_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_scl_level,
   output logic               rsp_sda_release,
   output logic [7:0]         rsp_rd_byte,
   output logic               rsp_rd_valid,
   output logic               rsp_rd_last,
   output logic               rsp_nack_seen,
   output logic               rsp_busy_res,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [TIMER_W-1:0] csr_data
);

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;
   result_type result;
   cfg_type    cfg;
   logic       out_free, step;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready)
         in_valid_in = 1'b1;
      else if (step)
         in_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (step)
         out_valid_in = 1'b1;
      else if (rsp_ready)
         out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.req_type <= req_type;
         item_ff.reg_addr <= req_reg_addr;
         item_ff.wr_data  <= req_wr_data;
         item_ff.rd_count <= req_rd_count;
         item_ff.sda_in   <= req_sda_in;
      end
      if (step)
         out_ff <= result;
   end

   i2crm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   i2crm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_scl_level   = out_ff.scl_level;
   assign rsp_sda_release = out_ff.sda_release;
   assign rsp_rd_byte     = out_ff.rd_byte;
   assign rsp_rd_valid    = out_ff.rd_valid;
   assign rsp_rd_last     = out_ff.rd_last;
   assign rsp_nack_seen   = out_ff.nack_seen;
   assign rsp_busy_res    = out_ff.busy_res;

endmodule

/* src/i2crm_csr.sv */
// ----------------------------------------------------------------------------
// i2crm_csr
// Configuration registers: device address and ticks per pin phase.
// ----------------------------------------------------------------------------
module i2crm_csr
   import i2crm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [TIMER_W-1:0] csr_data,
   output cfg_type            cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEVICE_ADDRESS: cfg_in.device_address    = csr_data[6:0];
            CSR_HALF_PERIOD:    cfg_in.half_period_ticks = csr_data;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.device_address    <= DEVICE_ADDRESS_RESET;
         cfg_ff.half_period_ticks <= HALF_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* src/i2crm_core.sv */
// ----------------------------------------------------------------------------
// i2crm_core
// Bus sequencer: one tick per step, drives pins and gathers read bytes.
// ----------------------------------------------------------------------------
module i2crm_core
   import i2crm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   seg_type            seg_ff, seg_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic [3:0]         bit_ff, bit_in;
   logic [7:0]         shift_ff, shift_in;
   logic [BURST_W-1:0] left_ff, left_in;
   logic               held_write_ff, held_write_in;
   logic [7:0]         held_reg_ff, held_reg_in;
   logic [7:0]         held_data_ff, held_data_in;
   logic [1:0]         pins_ff, pins_in;
   logic               nack_ff, nack_in;
   logic [2:0]         sub_ff, sub_in;

   // state as seen after a possible start of a transaction on this tick
   seg_type            e_seg;
   logic [TIMER_W-1:0] e_timer;
   logic [3:0]         e_bit;
   logic [7:0]         e_shift;
   logic [BURST_W-1:0] e_left;
   logic               e_nack;
   logic [2:0]         e_sub;

   logic [TIMER_W-1:0] h;
   logic               wseg, sample_ack, sample_bit, done, scl, sda;
   logic [2:0]         last;
   logic [7:0]         addr_byte;
   logic [7:0]         sampled;

   always_comb begin
      e_seg         = seg_ff;
      e_timer       = timer_ff;
      e_bit         = bit_ff;
      e_shift       = shift_ff;
      e_left        = left_ff;
      e_nack        = nack_ff;
      e_sub         = sub_ff;
      held_write_in = held_write_ff;
      held_reg_in   = held_reg_ff;
      held_data_in  = held_data_ff;
      if (seg_ff == SEG_IDLE &&
          (item.req_type == REQ_WRITE || item.req_type == REQ_READ)) begin
         held_write_in = (item.req_type == REQ_WRITE);
         held_reg_in   = item.reg_addr;
         held_data_in  = item.wr_data;
         if (item.rd_count == '0)
            e_left = BURST_W'(1);
         else if (item.rd_count > BURST_W'(MAX_BURST))
            e_left = BURST_W'(MAX_BURST);
         else
            e_left = item.rd_count;
         e_nack  = 1'b0;
         e_timer = '0;
         e_seg   = SEG_START;
         e_shift = '0;
         e_bit   = '0;
         e_sub   = '0;
      end
   end

   always_comb begin
      h          = (cfg.half_period_ticks == '0) ? TIMER_W'(1) : cfg.half_period_ticks;
      wseg       = (e_seg == SEG_ADDRW || e_seg == SEG_REG ||
                    e_seg == SEG_DATA  || e_seg == SEG_ADDRR);
      sample_ack = 1'b0;
      sample_bit = 1'b0;
      scl        = pins_ff[1];
      sda        = pins_ff[0];
      last       = 3'd0;
      addr_byte  = {cfg.device_address, 1'b0};
      sampled    = {e_shift[6:0], item.sda_in};
      done       = ({1'b0, e_timer} + (TIMER_W+1)'(1)) >= {1'b0, h};

      seg_in   = e_seg;
      timer_in = e_timer;
      bit_in   = e_bit;
      shift_in = e_shift;
      left_in  = e_left;
      nack_in  = e_nack;
      sub_in   = e_sub;
      pins_in  = pins_ff;

      result.rd_byte  = '0;
      result.rd_valid = 1'b0;
      result.rd_last  = 1'b0;
      result.busy_res = 1'b0;

      unique case (e_seg)
         SEG_START, SEG_RSTART: begin
            unique case (e_sub[1:0])
               2'd0:    scl = (e_seg == SEG_START);
               2'd1:    scl = 1'b1;
               2'd2:    scl = 1'b1;
               default: scl = 1'b0;
            endcase
            sda  = (e_sub[1:0] < 2'd2);
            last = 3'd3;
         end
         SEG_STOP: begin
            scl  = (e_sub >= 3'd2);
            sda  = (e_sub == 3'd0) || (e_sub >= 3'd3);
            last = 3'd4;
         end
         SEG_ADDRW, SEG_REG, SEG_DATA, SEG_ADDRR: begin
            if (e_bit < 4'd8) begin
               sda  = e_shift[7];
               scl  = (e_sub == 3'd1);
               last = 3'd2;
            end else begin
               sda        = 1'b1;
               scl        = (e_sub == 3'd0);
               sample_ack = (e_sub == 3'd0);
               last       = 3'd1;
            end
         end
         SEG_READ: begin
            if (e_bit < 4'd8) begin
               sda        = 1'b1;
               scl        = (e_sub == 3'd0);
               sample_bit = (e_sub == 3'd0);
               last       = 3'd1;
            end else begin
               // ack every byte but the last
               sda  = !(e_left > BURST_W'(1));
               scl  = (e_sub == 3'd1);
               last = 3'd2;
            end
         end
         default: begin
            scl = pins_ff[1];
            sda = pins_ff[0];
         end
      endcase

      if (e_seg != SEG_IDLE) begin
         result.busy_res = 1'b1;
         pins_in         = {scl, sda};
         if (!done) begin
            timer_in = e_timer + TIMER_W'(1);
         end else begin
            timer_in = '0;
            if (sample_ack && item.sda_in)
               nack_in = 1'b1;
            if (sample_bit) begin
               shift_in = sampled;
               if (e_bit == 4'd7) begin
                  result.rd_valid = 1'b1;
                  result.rd_byte  = sampled;
                  result.rd_last  = (e_left <= BURST_W'(1));
               end
            end
            if (e_sub < last) begin
               sub_in = e_sub + 3'd1;
            end else if (wseg && e_bit < 4'd8) begin
               sub_in   = '0;
               shift_in = {e_shift[6:0], 1'b0};
               bit_in   = e_bit + 4'd1;
            end else if (e_seg == SEG_READ && e_bit < 4'd8) begin
               sub_in = '0;
               bit_in = e_bit + 4'd1;
            end else begin
               sub_in = '0;
               bit_in = '0;
               unique case (e_seg)
                  SEG_START: begin
                     seg_in   = SEG_ADDRW;
                     shift_in = addr_byte;
                  end
                  SEG_ADDRW: begin
                     seg_in   = SEG_REG;
                     shift_in = held_reg_ff;
                  end
                  SEG_REG: begin
                     if (held_write_ff) begin
                        seg_in   = SEG_DATA;
                        shift_in = held_data_ff;
                     end else begin
                        seg_in   = SEG_RSTART;
                        shift_in = '0;
                     end
                  end
                  SEG_DATA: begin
                     seg_in   = SEG_STOP;
                     shift_in = '0;
                  end
                  SEG_RSTART: begin
                     seg_in   = SEG_ADDRR;
                     shift_in = {cfg.device_address, 1'b1};
                  end
                  SEG_ADDRR: begin
                     seg_in   = SEG_READ;
                     shift_in = '0;
                  end
                  SEG_READ: begin
                     shift_in = '0;
                     if (e_left > BURST_W'(1)) begin
                        left_in = e_left - BURST_W'(1);
                        seg_in  = SEG_READ;
                     end else begin
                        left_in = '0;
                        seg_in  = SEG_STOP;
                     end
                  end
                  default: begin
                     seg_in   = SEG_IDLE;
                     shift_in = '0;
                  end
               endcase
            end
         end
      end

      result.scl_level   = scl;
      result.sda_release = sda;
      result.nack_seen   = nack_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff        <= SEG_IDLE;
         timer_ff      <= '0;
         bit_ff        <= '0;
         shift_ff      <= '0;
         left_ff       <= '0;
         held_write_ff <= 1'b0;
         held_reg_ff   <= '0;
         held_data_ff  <= '0;
         pins_ff       <= 2'b11;
         nack_ff       <= 1'b0;
         sub_ff        <= '0;
      end else if (step) begin
         seg_ff        <= seg_in;
         timer_ff      <= timer_in;
         bit_ff        <= bit_in;
         shift_ff      <= shift_in;
         left_ff       <= left_in;
         held_write_ff <= held_write_in;
         held_reg_ff   <= held_reg_in;
         held_data_ff  <= held_data_in;
         pins_ff       <= pins_in;
         nack_ff       <= nack_in;
         sub_ff        <= sub_in;
      end
   end

endmodule

/* src/i2crm_checker.sv */
// ----------------------------------------------------------------------------
// i2crm_checker
// Port-level checks on the result channel of the I2C register master.
// ----------------------------------------------------------------------------
module i2crm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl_level,
   input logic       rsp_sda_release,
   input logic [7:0] rsp_rd_byte,
   input logic       rsp_rd_valid,
   input logic       rsp_rd_last,
   input logic       rsp_busy_res
);

   // last byte flag only rides with a received byte
   a_last_with_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rd_last |-> rsp_rd_valid)
      else $error("rd_last without rd_valid");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_rd_valid |-> rsp_rd_byte == 8'd0)
      else $error("rd_byte nonzero without rd_valid");

   // bytes are sampled with scl high and sda released, inside a transaction
   a_sample_pins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rd_valid |-> rsp_scl_level && rsp_sda_release && rsp_busy_res)
      else $error("read byte outside a released clock-high phase");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rd_byte)
         && $stable(rsp_scl_level) && $stable(rsp_sda_release))
      else $error("stalled transaction changed");

endmodule

bind i2c_register_master_top i2crm_checker u_checker (.*);
